[hdl/brs_pkg.sv]
// Package for the branch resolution unit: command codes, target selects,
// address constants and the stage records passed down the pipeline.
// No dependencies.
package brs_pkg;

    // Branch and jump command codes
    typedef enum logic [4:0] {
        CMD_BEQ     = 5'd0,
        CMD_BNE     = 5'd1,
        CMD_BEQL    = 5'd2,
        CMD_BNEL    = 5'd3,
        CMD_BGEZ    = 5'd4,
        CMD_BGTZ    = 5'd5,
        CMD_BLEZ    = 5'd6,
        CMD_BLTZ    = 5'd7,
        CMD_BGEZL   = 5'd8,
        CMD_BGTZL   = 5'd9,
        CMD_BLEZL   = 5'd10,
        CMD_BLTZL   = 5'd11,
        CMD_BGEZAL  = 5'd12,
        CMD_BLTZAL  = 5'd13,
        CMD_BGEZALL = 5'd14,
        CMD_BLTZALL = 5'd15,
        CMD_J       = 5'd16,
        CMD_JAL     = 5'd17,
        CMD_JR      = 5'd18,
        CMD_JALR    = 5'd19
    } cmd_t;

    // Source of the next program counter
    typedef enum logic [1:0] {
        SEL_FALL   = 2'd0,
        SEL_BRANCH = 2'd1,
        SEL_JUMP   = 2'd2,
        SEL_REG    = 2'd3
    } next_sel_t;

    localparam logic [31:0] SEGMENT_MASK = 32'hf000_0000;
    localparam logic [4:0]  RETURN_REG   = 5'd31;
    localparam logic [31:0] WORD_BYTES   = 32'd4;

    // Decode stage record: operands captured, register compares done
    typedef struct packed {
        logic        valid;
        cmd_t        cmd;
        logic [31:0] slot;
        logic [15:0] offset;
        logic [25:0] jump_index;
        logic [31:0] rs_low;
        logic        eq;
        logic        neg;
        logic        zero;
        logic [4:0]  link_index;
    } s1_t;

    // Resolve stage record: condition settled, candidate addresses formed
    typedef struct packed {
        logic        valid;
        logic        taken;
        logic        run_slot;
        next_sel_t   sel;
        logic [31:0] fall;
        logic [31:0] btarget;
        logic [31:0] jtarget;
        logic [31:0] rtarget;
        logic        link_valid;
        logic [4:0]  link_target;
        logic        link_sext;
    } s2_t;

endpackage

[hdl/brs_decode.sv]
// First pipeline stage: captures a transaction and runs the 64-bit
// register compares. Depends on brs_pkg.
module brs_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [4:0]          command,
    input  logic [31:0]         slot_address,
    input  logic signed [15:0]  offset,
    input  logic [25:0]         jump_index,
    input  logic signed [63:0]  first_value,
    input  logic signed [63:0]  second_value,
    input  logic [4:0]          link_index,
    output brs_pkg::s1_t        s1
);

    brs_pkg::s1_t s1_reg;
    brs_pkg::s1_t s1_next;

    // Compare rs against rt and against zero
    always_comb
    begin
        s1_next.valid      = start;
        s1_next.cmd        = brs_pkg::cmd_t'(command);
        s1_next.slot       = slot_address;
        s1_next.offset     = offset;
        s1_next.jump_index = jump_index;
        s1_next.rs_low     = first_value[31:0];
        s1_next.eq         = (first_value == second_value);
        s1_next.neg        = first_value[63];
        s1_next.zero       = (first_value == 64'sd0);
        s1_next.link_index = link_index;
    end

    // Stage register; valid bit and payload clear together on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

[hdl/brs_resolve.sv]
// Second pipeline stage: settles the branch condition, the delay-slot
// decision and the link write, and forms candidate addresses. Depends on brs_pkg.
module brs_resolve (
    input  logic         clk,
    input  logic         rst_n,
    input  brs_pkg::s1_t s1,
    output brs_pkg::s2_t s2
);

    brs_pkg::s2_t s2_reg;
    brs_pkg::s2_t s2_next;
    logic         taken;
    logic         likely;
    logic [31:0]  off_bytes;

    // Branch condition per command
    always_comb
    begin
        case (s1.cmd)
            brs_pkg::CMD_BEQ, brs_pkg::CMD_BEQL:
                taken = s1.eq;
            brs_pkg::CMD_BNE, brs_pkg::CMD_BNEL:
                taken = !s1.eq;
            brs_pkg::CMD_BGEZ, brs_pkg::CMD_BGEZL,
            brs_pkg::CMD_BGEZAL, brs_pkg::CMD_BGEZALL:
                taken = !s1.neg;
            brs_pkg::CMD_BGTZ, brs_pkg::CMD_BGTZL:
                taken = !s1.neg && !s1.zero;
            brs_pkg::CMD_BLEZ, brs_pkg::CMD_BLEZL:
                taken = s1.neg || s1.zero;
            brs_pkg::CMD_BLTZ, brs_pkg::CMD_BLTZL,
            brs_pkg::CMD_BLTZAL, brs_pkg::CMD_BLTZALL:
                taken = s1.neg;
            brs_pkg::CMD_J, brs_pkg::CMD_JAL,
            brs_pkg::CMD_JR, brs_pkg::CMD_JALR:
                taken = 1'b1;
            default:
                taken = 1'b0;
        endcase
    end

    assign likely = s1.cmd inside {brs_pkg::CMD_BEQL, brs_pkg::CMD_BNEL,
                                   brs_pkg::CMD_BGEZL, brs_pkg::CMD_BGTZL,
                                   brs_pkg::CMD_BLEZL, brs_pkg::CMD_BLTZL,
                                   brs_pkg::CMD_BGEZALL, brs_pkg::CMD_BLTZALL};

    // Word offset to bytes, sign extended
    assign off_bytes = {{14{s1.offset[15]}}, s1.offset, 2'b00};

    // Next-PC source and link write
    always_comb
    begin
        s2_next.valid       = s1.valid;
        s2_next.taken       = taken;
        s2_next.run_slot    = !(likely && !taken);
        s2_next.fall        = s1.slot + brs_pkg::WORD_BYTES;
        s2_next.btarget     = s1.slot + off_bytes;
        s2_next.jtarget     = (s1.slot & brs_pkg::SEGMENT_MASK)
                            | {4'b0000, s1.jump_index, 2'b00};
        s2_next.rtarget     = s1.rs_low;
        s2_next.link_valid  = 1'b0;
        s2_next.link_target = 5'd0;
        s2_next.link_sext   = 1'b0;
        case (s1.cmd)
            brs_pkg::CMD_BGEZAL, brs_pkg::CMD_BLTZAL,
            brs_pkg::CMD_BGEZALL, brs_pkg::CMD_BLTZALL:
            begin
                s2_next.sel         = taken ? brs_pkg::SEL_BRANCH : brs_pkg::SEL_FALL;
                s2_next.link_valid  = 1'b1;
                s2_next.link_target = brs_pkg::RETURN_REG;
                s2_next.link_sext   = 1'b1;
            end
            brs_pkg::CMD_J:
                s2_next.sel = brs_pkg::SEL_JUMP;
            brs_pkg::CMD_JAL:
            begin
                s2_next.sel         = brs_pkg::SEL_JUMP;
                s2_next.link_valid  = 1'b1;
                s2_next.link_target = brs_pkg::RETURN_REG;
            end
            brs_pkg::CMD_JR:
                s2_next.sel = brs_pkg::SEL_REG;
            brs_pkg::CMD_JALR:
            begin
                // link index zero acts as JR
                s2_next.sel         = brs_pkg::SEL_REG;
                s2_next.link_valid  = (s1.link_index != 5'd0);
                s2_next.link_target = s1.link_index;
            end
            default:
                // conditional branches; unused codes are never taken
                s2_next.sel = taken ? brs_pkg::SEL_BRANCH : brs_pkg::SEL_FALL;
        endcase
    end

    // Stage register; valid bit and payload clear together on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

[hdl/brs_output.sv]
// Third pipeline stage: picks the next PC, forms the link value and
// registers the result with its strobe. Depends on brs_pkg.
module brs_output (
    input  logic         clk,
    input  logic         rst_n,
    input  brs_pkg::s2_t s2,
    output logic         done,
    output logic         taken,
    output logic [31:0]  next_address,
    output logic         run_slot,
    output logic         link_valid,
    output logic [4:0]   link_target,
    output logic [63:0]  link_value
);

    logic        done_reg;
    logic        taken_reg;
    logic [31:0] next_address_reg;
    logic [31:0] next_address_next;
    logic        run_slot_reg;
    logic        link_valid_reg;
    logic [4:0]  link_target_reg;
    logic [63:0] link_value_reg;
    logic [63:0] link_value_next;

    // Next-PC mux
    always_comb
    begin
        case (s2.sel)
            brs_pkg::SEL_BRANCH: next_address_next = s2.btarget;
            brs_pkg::SEL_JUMP:   next_address_next = s2.jtarget;
            brs_pkg::SEL_REG:    next_address_next = s2.rtarget;
            default:             next_address_next = s2.fall;
        endcase
    end

    // Link value: zero when no link, else sign or zero extended return address
    always_comb
    begin
        if (!s2.link_valid)
        begin
            link_value_next = 64'd0;
        end
        else if (s2.link_sext)
        begin
            link_value_next = {{32{s2.fall[31]}}, s2.fall};
        end
        else
        begin
            link_value_next = {32'd0, s2.fall};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        taken_reg        <= s2.taken;
        next_address_reg <= next_address_next;
        run_slot_reg     <= s2.run_slot;
        link_valid_reg   <= s2.link_valid;
        link_target_reg  <= s2.link_valid ? s2.link_target : 5'd0;
        link_value_reg   <= link_value_next;
    end

    assign done         = done_reg;
    assign taken        = taken_reg;
    assign next_address = next_address_reg;
    assign run_slot     = run_slot_reg;
    assign link_valid   = link_valid_reg;
    assign link_target  = link_target_reg;
    assign link_value   = link_value_reg;

endmodule

[hdl/mips_branch_resolution_unit.sv]
// Branch and jump resolution unit for a 64-bit MIPS-style core.
// The decode, resolve and output registers lie in order between the accepting edge and the done strobe.
// Throughput: one transaction per cycle; busy is never asserted, the three
// register stages (decode/compare, resolve, output) advance every cycle.
// Reset: rst_n clears the decode and resolve stages and the done strobe at
// once; the result payload registers are not reset. Results are strobed on
// done for one cycle and cannot be held off.
module mips_branch_resolution_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [4:0]         command,
    input  logic [31:0]        slot_address,
    input  logic signed [15:0] offset,
    input  logic [25:0]        jump_index,
    input  logic signed [63:0] first_value,
    input  logic signed [63:0] second_value,
    input  logic [4:0]         link_index,
    output logic               done,
    output logic               taken,
    output logic [31:0]        next_address,
    output logic               run_slot,
    output logic               link_valid,
    output logic [4:0]         link_target,
    output logic [63:0]        link_value
);

    brs_pkg::s1_t s1;
    brs_pkg::s2_t s2;

    // Pipeline never stalls
    assign busy = 1'b0;

    brs_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .slot_address (slot_address),
        .offset       (offset),
        .jump_index   (jump_index),
        .first_value  (first_value),
        .second_value (second_value),
        .link_index   (link_index),
        .s1           (s1)
    );

    brs_resolve u_resolve (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    brs_output u_output (
        .clk          (clk),
        .rst_n        (rst_n),
        .s2           (s2),
        .done         (done),
        .taken        (taken),
        .next_address (next_address),
        .run_slot     (run_slot),
        .link_valid   (link_valid),
        .link_target  (link_target),
        .link_value   (link_value)
    );

`ifndef NO_ASSERTIONS
    // Every accepted transaction later produces a result on done
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted transaction produced no result");

    // No result without a matching transaction
    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("result strobe without a transaction");

    // A not-taken result falls through past the delay slot
    a_fall_through: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !taken) |-> (next_address == $past(slot_address, 3) + 32'd4))
        else $error("not-taken result has wrong next address");

    // Without a link write the link fields are zero
    a_no_link: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !link_valid) |-> (link_target == 5'd0 && link_value == 64'd0))
        else $error("link fields set without a link write");
`endif

endmodule

[verif/tb_mips_branch_resolution_unit.sv]
// Self-checking testbench for mips_branch_resolution_unit: a directed table
// then random branch/jump transactions, checked against hand-written results or a local resolver.
// Depends on brs_pkg (hdl/brs_pkg.sv) and the unit itself.
module tb_mips_branch_resolution_unit;

    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_TAIL   = 200;
    localparam int STALL_LIMIT  = 500;
    localparam int PIPE_DEPTH   = 3;
    localparam int MAX_PRINTED  = 40;

    // One branch/jump request as presented on the input ports
    typedef struct packed {
        logic [4:0]  command;
        logic [31:0] slot;
        logic [15:0] offset;
        logic [25:0] jidx;
        logic [63:0] rs;
        logic [63:0] rt;
        logic [4:0]  link_index;
    } branch_req_t;

    // Resolution of one request as seen on the result ports
    typedef struct packed {
        logic        taken;
        logic [31:0] next_pc;
        logic        run;
        logic        lvalid;
        logic [4:0]  ltarget;
        logic [63:0] lvalue;
    } branch_res_t;

    // Directed row: request plus an optional hand-written resolution
    typedef struct {
        branch_req_t req;
        bit          typed;
        branch_res_t want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [4:0]         command;
    logic [31:0]        slot_address;
    logic signed [15:0] offset;
    logic [25:0]        jump_index;
    logic signed [63:0] first_value;
    logic signed [63:0] second_value;
    logic [4:0]         link_index;
    logic               done;
    logic               taken;
    logic [31:0]        next_address;
    logic               run_slot;
    logic               link_valid;
    logic [4:0]         link_target;
    logic [63:0]        link_value;

    branch_res_t pending_resolutions[$];
    dir_row_t    directed_rows[$];

    int error_count;
    int resolved_count;
    int taken_count;
    int cancelled_count;
    int link_count;
    int accepted_count;
    int stall_cycles;

    mips_branch_resolution_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .slot_address (slot_address),
        .offset       (offset),
        .jump_index   (jump_index),
        .first_value  (first_value),
        .second_value (second_value),
        .link_index   (link_index),
        .done         (done),
        .taken        (taken),
        .next_address (next_address),
        .run_slot     (run_slot),
        .link_valid   (link_valid),
        .link_target  (link_target),
        .link_value   (link_value)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Mismatch reporting; printing is capped, counting is not
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH @%0t %s: got %h expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Resolver: taken flag, next PC, delay-slot fate and link write
    function automatic branch_res_t resolve_branch(input branch_req_t r);
        branch_res_t res;
        logic [31:0] fall;
        logic [31:0] target;
        logic        eq;
        logic        neg;
        logic        zero;
        logic        likely;
        res    = '0;
        fall   = r.slot + brs_pkg::WORD_BYTES;
        target = r.slot + {{14{r.offset[15]}}, r.offset, 2'b00};
        eq     = (r.rs == r.rt);
        neg    = r.rs[63];
        zero   = (r.rs == '0);
        likely = r.command inside {brs_pkg::CMD_BEQL, brs_pkg::CMD_BNEL,
                                   brs_pkg::CMD_BGEZL, brs_pkg::CMD_BGTZL,
                                   brs_pkg::CMD_BLEZL, brs_pkg::CMD_BLTZL,
                                   brs_pkg::CMD_BGEZALL, brs_pkg::CMD_BLTZALL};
        res.next_pc = fall;

        // condition and target
        case (r.command)
            brs_pkg::CMD_BEQ, brs_pkg::CMD_BEQL:
                res.taken = eq;
            brs_pkg::CMD_BNE, brs_pkg::CMD_BNEL:
                res.taken = !eq;
            brs_pkg::CMD_BGEZ, brs_pkg::CMD_BGEZL,
            brs_pkg::CMD_BGEZAL, brs_pkg::CMD_BGEZALL:
                res.taken = !neg;
            brs_pkg::CMD_BGTZ, brs_pkg::CMD_BGTZL:
                res.taken = !neg && !zero;
            brs_pkg::CMD_BLEZ, brs_pkg::CMD_BLEZL:
                res.taken = neg || zero;
            brs_pkg::CMD_BLTZ, brs_pkg::CMD_BLTZL,
            brs_pkg::CMD_BLTZAL, brs_pkg::CMD_BLTZALL:
                res.taken = neg;
            brs_pkg::CMD_J, brs_pkg::CMD_JAL:
            begin
                res.taken   = 1'b1;
                res.next_pc = (r.slot & brs_pkg::SEGMENT_MASK)
                            | {4'b0000, r.jidx, 2'b00};
            end
            brs_pkg::CMD_JR, brs_pkg::CMD_JALR:
            begin
                res.taken   = 1'b1;
                res.next_pc = r.rs[31:0];
            end
            default: ;  // unused codes fall through
        endcase
        if (r.command < brs_pkg::CMD_J && res.taken)
            res.next_pc = target;

        // link write: BxxZAL always links, sign-extended; JAL/JALR zero-extend
        case (r.command)
            brs_pkg::CMD_BGEZAL, brs_pkg::CMD_BLTZAL,
            brs_pkg::CMD_BGEZALL, brs_pkg::CMD_BLTZALL:
            begin
                res.lvalid  = 1'b1;
                res.ltarget = brs_pkg::RETURN_REG;
                res.lvalue  = {{32{fall[31]}}, fall};
            end
            brs_pkg::CMD_JAL:
            begin
                res.lvalid  = 1'b1;
                res.ltarget = brs_pkg::RETURN_REG;
                res.lvalue  = {32'h0, fall};
            end
            brs_pkg::CMD_JALR:
            begin
                if (r.link_index != 5'd0)
                begin
                    res.lvalid  = 1'b1;
                    res.ltarget = r.link_index;
                    res.lvalue  = {32'h0, fall};
                end
            end
            default: ;
        endcase

        res.run = !(likely && !res.taken);
        return res;
    endfunction

    function automatic branch_res_t mk_res(input logic tk, input logic [31:0] pc,
                                           input logic run, input logic lv,
                                           input logic [4:0] lt, input logic [63:0] lval);
        branch_res_t res;
        res = '{taken: tk, next_pc: pc, run: run, lvalid: lv, ltarget: lt, lvalue: lval};
        return res;
    endfunction

    function automatic void add_row(input logic [4:0] cmd, input logic [31:0] slot,
                                    input logic [15:0] off, input logic [25:0] jidx,
                                    input logic [63:0] rs, input logic [63:0] rt,
                                    input logic [4:0] li, input bit typed,
                                    input branch_res_t want);
        dir_row_t row;
        row.req   = '{command: cmd, slot: slot, offset: off, jidx: jidx,
                      rs: rs, rt: rt, link_index: li};
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // Operand mix: extremes and small values often, full random otherwise
    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            3: v = 64'h7fff_ffff_ffff_ffff;
            4:
            begin
                v = 64'($urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic branch_req_t rand_request();
        branch_req_t r;
        if ($urandom_range(0, 15) == 0)
            r.command = 5'($urandom_range(20, 31));
        else
            r.command = 5'($urandom_range(0, 19));
        r.slot   = $urandom;
        r.offset = 16'($urandom);
        r.jidx   = 26'($urandom);
        r.rs     = rand_operand();
        // equal operands often so BEQ/BNE split both ways
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r.rt = r.rs;
            4:          r.rt = r.rs ^ (64'd1 << $urandom_range(0, 63));
            default:    r.rt = rand_operand();
        endcase
        r.link_index = ($urandom_range(0, 5) == 0) ? 5'd0 : 5'($urandom);
        return r;
    endfunction

    task automatic drive_fields(input branch_req_t r);
        command      <= r.command;
        slot_address <= r.slot;
        offset       <= r.offset;
        jump_index   <= r.jidx;
        first_value  <= r.rs;
        second_value <= r.rt;
        link_index   <= r.link_index;
    endtask

    // Present one transaction and hold it until accepted
    task automatic issue(input branch_req_t r, input bit typed, input branch_res_t want);
        drive_fields(r);
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_resolutions.push_back(typed ? want : resolve_branch(r));
        accepted_count++;
    endtask

    // Sender idle burst, with noise on the payload
    task automatic pause(input int cycles);
        start <= 1'b0;
        drive_fields(rand_request());
        repeat (cycles)
            @(posedge clk);
    endtask

    // Sender holds off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        while (pending_resolutions.size() != 0)
            @(posedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        branch_res_t want;
        if (rst_n && done)
        begin
            if (pending_resolutions.size() == 0)
                report_mismatch("result with no transaction outstanding",
                                {32'h0, next_address}, '0);
            else
            begin
                want = pending_resolutions.pop_front();
                if (taken !== want.taken)
                    report_mismatch("taken", 64'(taken), 64'(want.taken));
                if (next_address !== want.next_pc)
                    report_mismatch("next_address", 64'(next_address), 64'(want.next_pc));
                if (run_slot !== want.run)
                    report_mismatch("run_slot", 64'(run_slot), 64'(want.run));
                if (link_valid !== want.lvalid)
                    report_mismatch("link_valid", 64'(link_valid), 64'(want.lvalid));
                if (link_target !== want.ltarget)
                    report_mismatch("link_target", 64'(link_target), 64'(want.ltarget));
                if (link_value !== want.lvalue)
                    report_mismatch("link_value", link_value, want.lvalue);
                resolved_count++;
                if (want.taken)
                    taken_count++;
                if (!want.run)
                    cancelled_count++;
                if (want.lvalid)
                    link_count++;
            end
        end
    end

    // Watchdog on cycles with no transaction either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TIMEOUT: %0d idle cycles, %0d results outstanding",
                     stall_cycles, pending_resolutions.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        branch_res_t none;
        bit          quiet;
        none         = '0;
        quiet        = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = '0;
        slot_address = '0;
        offset       = '0;
        jump_index   = '0;
        first_value  = '0;
        second_value = '0;
        link_index   = '0;

        // cmd, slot, offset, jump index, rs, rt, link index, typed, result
        add_row(brs_pkg::CMD_BEQ, 32'h0000_1000, 16'h0004, '0, '0, '0, 5'd0, 1,
                mk_res(1, 32'h0000_1010, 1, 0, 5'd0, '0));
        add_row(brs_pkg::CMD_BNE, 32'hffff_fffc, 16'h8000, '1,
                64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 5'd31, 0, none);
        add_row(brs_pkg::CMD_BEQL, 32'h8000_0000, 16'h0010, '0, 64'd1, 64'd2, 5'd0, 1,
                mk_res(0, 32'h8000_0004, 0, 0, 5'd0, '0));
        add_row(brs_pkg::CMD_BNEL, 32'h0040_0000, 16'hfffe, '0, '1, '1, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BGEZ, 32'h0000_2000, 16'h7fff, '0, '0, '1, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BGTZ, 32'h0000_2000, 16'h0001, '0, '0, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BLEZ, 32'h1234_5678, 16'hffff, '0,
                64'h8000_0000_0000_0000, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BLTZ, 32'h1234_5678, 16'h0002, '0,
                64'h7fff_ffff_ffff_ffff, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BGEZL, 32'h0000_3000, 16'h0020, '0, '1, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BGTZL, 32'h0000_3000, 16'h7fff, '0, 64'd1, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BLEZL, 32'h0000_3000, 16'h8000, '0, '0, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BLTZL, 32'h0000_3000, 16'h0008, '0, '0, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BGEZAL, 32'h7fff_fffc, 16'h0100, '0, '1, '0, 5'd0, 1,
                mk_res(0, 32'h8000_0000, 1, 1, brs_pkg::RETURN_REG,
                       64'hffff_ffff_8000_0000));
        add_row(brs_pkg::CMD_BLTZAL, 32'h0000_4000, 16'hff00, '0,
                64'h8000_0000_0000_0000, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_BGEZALL, 32'hdead_0000, 16'h0004, '0, -64'sd5, '0, 5'd0, 0,
                none);
        add_row(brs_pkg::CMD_BLTZALL, 32'hffff_fffc, 16'h0004, '0, '1, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_J, 32'hffff_fffc, '0, 26'h3ff_ffff, '0, '0, 5'd0, 1,
                mk_res(1, 32'hffff_fffc, 1, 0, 5'd0, '0));
        add_row(brs_pkg::CMD_J, 32'h0fff_fffc, '0, 26'h000_0000, '1, '1, 5'd0, 0, none);
        add_row(brs_pkg::CMD_JAL, 32'hffff_fff8, '0, 26'h012_3456, '0, '0, 5'd0, 0, none);
        add_row(brs_pkg::CMD_JR, 32'h0000_5000, '0, '0, 64'hdead_beef_1234_5678, '0,
                5'd0, 1, mk_res(1, 32'h1234_5678, 1, 0, 5'd0, '0));
        add_row(brs_pkg::CMD_JALR, 32'h0000_5000, '0, '0, 64'h0000_0000_0000_8000, '0,
                5'd0, 1, mk_res(1, 32'h0000_8000, 1, 0, 5'd0, '0));
        add_row(brs_pkg::CMD_JALR, 32'h7fff_fffc, '0, '0, '1, '0, 5'd31, 0, none);
        add_row(brs_pkg::CMD_JALR, 32'h0000_6000, '0, '0, 64'h8000_0000_ffff_fffc, '0,
                5'd5, 0, none);
        add_row(5'd20, 32'h0000_0100, 16'h0040, '1, '0, '0, 5'd7, 1,
                mk_res(0, 32'h0000_0104, 1, 0, 5'd0, '0));
        add_row(5'd31, 32'hffff_fffc, 16'hffff, '1, '1, '1, 5'd31, 1,
                mk_res(0, 32'h0000_0000, 1, 0, 5'd0, '0));

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            if ($urandom_range(0, 3) == 0)
                pause($urandom_range(1, 14));
        end
        drain();

        // random part: randomly mixed quiet and bursty stretches, quiet tail
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_ITEMS / 2)
                drain();
            issue(rand_request(), 1'b0, none);
            if (!quiet && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                pause($urandom_range(1, 14));
        end
        drain();
        repeat (PIPE_DEPTH + 2)
            @(posedge clk);

        $display("Checked %0d of %0d transactions: directed table plus random mix", 
                 resolved_count, accepted_count);
        $display("  over all 32 command codes; %0d taken, %0d slots cancelled, %0d links",
                 taken_count, cancelled_count, link_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
hdl/brs_pkg.sv
hdl/brs_decode.sv
hdl/brs_resolve.sv
hdl/brs_output.sv
hdl/mips_branch_resolution_unit.sv
verif/tb_mips_branch_resolution_unit.sv
